// ===== rtl/bresenham_line_stepper_top_macros.svh =====
// Assertion macros used by the line stepper RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef BRESENHAM_LINE_STEPPER_TOP_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_TOP_MACROS_SVH

// Same-cycle implication: whenever a holds, c holds.
`define BLS_ASSERT_IMP(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication: whenever a holds, c holds in the following cycle.
`define BLS_ASSERT_NXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/bls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg
// Shared codes and types for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    // input word kinds, carried on s_axis_tuser
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // per-line orientation flags
    typedef struct packed {
        logic minor_down;
        logic axes_swapped;
    } line_flags_t;

endpackage

// ===== rtl/bls_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_setup
// Line setup: picks the major axis, orders endpoints, derives the deltas.
// ----------------------------------------------------------------------------
module bls_setup
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] major_pos,
    output logic [COORD_BITS-1:0] major_end,
    output logic [COORD_BITS-1:0] minor_pos,
    output logic [COORD_BITS-1:0] major_delta,
    output logic [COORD_BITS:0]   twice_minor_delta,
    output line_flags_t           flags
);

    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  steep;
    logic [COORD_BITS-1:0] ma0;
    logic [COORD_BITS-1:0] mi0;
    logic [COORD_BITS-1:0] ma1;
    logic [COORD_BITS-1:0] mi1;
    logic                  reorder;
    logic [COORD_BITS-1:0] mi_first;
    logic [COORD_BITS-1:0] mi_last;
    logic [COORD_BITS-1:0] minor_delta;

    always_comb
    begin
        adx   = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
        ady   = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
        steep = (adx < ady);

        ma0 = steep ? start_y : start_x;
        mi0 = steep ? start_x : start_y;
        ma1 = steep ? end_y   : end_x;
        mi1 = steep ? end_x   : end_y;

        reorder   = (ma0 > ma1);
        major_pos = reorder ? ma1 : ma0;
        major_end = reorder ? ma0 : ma1;
        mi_first  = reorder ? mi1 : mi0;
        mi_last   = reorder ? mi0 : mi1;
        minor_pos = mi_first;

        major_delta = major_end - major_pos;
        minor_delta = (mi_last > mi_first) ? (mi_last - mi_first) : (mi_first - mi_last);
        twice_minor_delta = {minor_delta, 1'b0};

        flags.minor_down   = !(mi_last > mi_first);
        flags.axes_swapped = steep;
    end

endmodule

// ===== rtl/bls_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_step
// Line state registers with the pixel emit and error-term advance.
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_top_macros.svh"

module bls_step
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  advance,
    input  logic [COORD_BITS-1:0] set_major_pos,
    input  logic [COORD_BITS-1:0] set_major_end,
    input  logic [COORD_BITS-1:0] set_minor_pos,
    input  logic [COORD_BITS-1:0] set_major_delta,
    input  logic [COORD_BITS:0]   set_twice_minor_delta,
    input  line_flags_t           set_flags,
    output logic                  emit,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);

    localparam int ERR_W = COORD_BITS + 3;

    logic [COORD_BITS-1:0] major_pos_reg,   major_pos_next;
    logic [COORD_BITS-1:0] major_end_reg,   major_end_next;
    logic [COORD_BITS-1:0] minor_pos_reg,   minor_pos_next;
    logic [COORD_BITS-1:0] major_delta_reg, major_delta_next;
    logic [COORD_BITS:0]   tmd_reg,         tmd_next;
    logic signed [ERR_W-1:0] err_reg,       err_next;
    line_flags_t           flags_reg,       flags_next;
    logic                  line_active_reg, line_active_next;

    logic                    fire;
    logic [COORD_BITS-1:0]   cur_major;
    logic [COORD_BITS-1:0]   cur_minor;
    logic signed [ERR_W-1:0] err_sum;
    logic signed [ERR_W-1:0] md_ext;
    logic                    step_minor;

    always_comb
    begin
        // a start reloads everything; an advance continues the stored line
        major_pos_next   = start ? set_major_pos         : major_pos_reg;
        major_end_next   = start ? set_major_end         : major_end_reg;
        minor_pos_next   = start ? set_minor_pos         : minor_pos_reg;
        major_delta_next = start ? set_major_delta       : major_delta_reg;
        tmd_next         = start ? set_twice_minor_delta : tmd_reg;
        flags_next       = start ? set_flags             : flags_reg;
        err_next         = start ? '0                    : err_reg;
        line_active_next = line_active_reg;

        cur_major = major_pos_next;
        cur_minor = minor_pos_next;

        emit       = start || line_active_reg;
        fire       = start || (advance && line_active_reg);
        last_pixel = (major_pos_next == major_end_next);
        pixel_x    = flags_next.axes_swapped ? cur_minor : cur_major;
        pixel_y    = flags_next.axes_swapped ? cur_major : cur_minor;

        md_ext     = $signed({3'b000, major_delta_next});
        err_sum    = err_next + $signed({2'b00, tmd_next});
        step_minor = (err_sum > md_ext);

        if (fire)
        begin
            err_next = step_minor ? (err_sum - $signed({2'b00, major_delta_next, 1'b0}))
                                  : err_sum;
            if (step_minor)
            begin
                minor_pos_next = flags_next.minor_down ? (cur_minor - 1'b1)
                                                       : (cur_minor + 1'b1);
            end
            major_pos_next   = cur_major + 1'b1;
            line_active_next = !last_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            major_delta_reg <= '0;
            tmd_reg         <= '0;
            err_reg         <= '0;
            flags_reg       <= '0;
            line_active_reg <= 1'b0;
        end
        else
        begin
            major_pos_reg   <= major_pos_next;
            major_end_reg   <= major_end_next;
            minor_pos_reg   <= minor_pos_next;
            major_delta_reg <= major_delta_next;
            tmd_reg         <= tmd_next;
            err_reg         <= err_next;
            flags_reg       <= flags_next;
            line_active_reg <= line_active_next;
        end
    end

    // error term never exceeds the major delta between pixels
    `BLS_ASSERT_IMP(a_err_bound, 1'b1, err_reg <= $signed({3'b000, major_delta_reg}), "error term above major delta")
    // minor slope never exceeds the major slope on a live line
    `BLS_ASSERT_IMP(a_slope, line_active_reg, {1'b0, tmd_reg} <= {1'b0, major_delta_reg, 1'b0}, "minor delta exceeds major delta")
    `BLS_ASSERT_NXT(a_last_ends, fire && last_pixel, !line_active_reg, "line still active after last pixel")
    `BLS_ASSERT_NXT(a_idle_hold, advance && !start && !line_active_reg, $stable(major_pos_reg) && $stable(minor_pos_reg) && !line_active_reg, "idle advance changed line state")

endmodule

// ===== rtl/bresenham_line_stepper_top.sv =====
`timescale 1ns / 1ps
// A pixel appears on m_axis in the cycle after its input word is taken.
// Takes one input word per cycle unless the output register is full and m_axis is stalled.
// s_axis_tready stays high while the output register is empty or being drained.
// Reset (rst_n low, async) idles the line, empties the output, zeroes draw_color.
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top
// Streaming Bresenham rasterizer: start words load a line, advance words step it.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_top
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    // configuration: draw_color
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata, // start_x, start_y, end_x, end_y
    input  logic        s_axis_tuser,                       // kind
    // pixel words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((2*COORD_BITS+32+7)/8)*8-1:0] m_axis_tdata, // pixel_x, pixel_y, pixel_color
    output logic        m_axis_tlast                           // last_pixel
);

    localparam int OUT_FIELDS_W = 2*COORD_BITS + 32;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    logic [31:0]           draw_color_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [31:0]           out_color_reg;
    logic                  out_last_reg;

    logic                  in_accept;
    logic                  do_start;
    logic                  do_advance;
    logic                  load_out;

    logic [COORD_BITS-1:0] su_major_pos;
    logic [COORD_BITS-1:0] su_major_end;
    logic [COORD_BITS-1:0] su_minor_pos;
    logic [COORD_BITS-1:0] su_major_delta;
    logic [COORD_BITS:0]   su_tmd;
    line_flags_t           su_flags;

    logic                  emit;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  plast;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign do_start      = in_accept && (s_axis_tuser == KIND_START);
    assign do_advance    = in_accept && (s_axis_tuser == KIND_ADVANCE);
    assign load_out      = in_accept && emit;

    bls_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .start_x           (s_axis_tdata[COORD_BITS-1:0]),
        .start_y           (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x             (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y             (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .major_pos         (su_major_pos),
        .major_end         (su_major_end),
        .minor_pos         (su_minor_pos),
        .major_delta       (su_major_delta),
        .twice_minor_delta (su_tmd),
        .flags             (su_flags)
    );

    bls_step #(.COORD_BITS(COORD_BITS)) u_step (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .start                 (do_start),
        .advance               (do_advance),
        .set_major_pos         (su_major_pos),
        .set_major_end         (su_major_end),
        .set_minor_pos         (su_minor_pos),
        .set_major_delta       (su_major_delta),
        .set_twice_minor_delta (su_tmd),
        .set_flags             (su_flags),
        .emit                  (emit),
        .pixel_x               (px),
        .pixel_y               (py),
        .last_pixel            (plast)
    );

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                draw_color_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_x_reg     <= px;
            out_y_reg     <= py;
            out_color_reg <= draw_color_reg;
            out_last_reg  <= plast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_color_reg, out_y_reg, out_x_reg});
    assign m_axis_tlast  = out_last_reg;

endmodule
